>>> rtl/bbwd_pkg.sv
// Shared types, constants and helper functions for the byte bus watchdog timer.
package bbwd_pkg;

  // Register window
  localparam int unsigned WindowSize = 12;
  localparam int unsigned IdxW       = $clog2(WindowSize);

  // Register offsets
  localparam logic [IdxW-1:0] OfsEnable  = IdxW'(1);
  localparam logic [IdxW-1:0] OfsReload  = IdxW'(2);
  // Timeout shadow lives at 4..7 and counter snapshot at 8..11, so the upper
  // two index bits pick the bank and the lower two the byte lane.
  localparam logic [1:0]      BankTimeout = 2'd1;
  localparam logic [1:0]      BankCounter = 2'd2;

  localparam logic [31:0] AllOnes = 32'hffff_ffff;

  // Reciprocal for byte % WindowSize
  localparam int unsigned ModShift = 16;
  localparam int unsigned ModRecip = (2 ** ModShift + WindowSize - 1) / WindowSize;

  typedef enum logic [2:0] {
    MODE_WR_MATCH = 3'd0,
    MODE_RD_MATCH = 3'd1,
    MODE_DATA_WR  = 3'd2,
    MODE_DATA_RD  = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_TICK     = 3'd5
  } mode_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       watchdog_fired;
  } result_t;

  // byte % WindowSize via reciprocal multiply plus one correction step
  function automatic logic [IdxW-1:0] byte_mod_window(logic [7:0] b);
    logic [23:0] prod;
    logic [8:0]  quo;
    logic [8:0]  rem;
    prod = 24'(b) * 24'(ModRecip);
    quo  = 9'(prod >> ModShift);
    rem  = 9'(b) - 9'(quo * 9'(WindowSize));
    if (rem >= 9'(WindowSize)) begin
      rem = rem - 9'(WindowSize);
    end
    return IdxW'(rem);
  endfunction

  function automatic logic [IdxW-1:0] next_index(logic [IdxW-1:0] idx);
    return (idx == IdxW'(WindowSize - 1)) ? '0 : idx + IdxW'(1);
  endfunction

endpackage

>>> rtl/bbwd_item_if.sv
// Valid/ready channel interfaces for input items and result items.
interface bbwd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] write_byte;

  modport source (output valid, output mode, output write_byte, input ready);
  modport sink   (input valid, input mode, input write_byte, output ready);
endinterface

interface bbwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       watchdog_fired;

  modport source (output valid, output read_byte, output watchdog_fired, input ready);
  modport sink   (input valid, input read_byte, input watchdog_fired, output ready);
endinterface

>>> rtl/byte_bus_watchdog_timer_unit.sv
// Top level of the byte bus watchdog timer: input register, core, result register.
//
// Usage:
//   in_i  carries one bus event per item: mode (write match, read match,
//         data write, data read, stop, tick) and write_byte for data writes.
//   out_o returns exactly one item per input item: read_byte (register byte
//         on a data read, else zero) and watchdog_fired (the enabled counter
//         hit zero; the block is back in its reset state afterwards).
// Path: an accepted item sits in the input register while the core works on it;
//   the result register loads when the core steps, and out_o.valid then rises.
// Throughput: one item per cycle while out_o.ready is high; the core does one register
//   update and one byte select per item, and both registers advance together.
// Stall: when out_o.ready is low with a result pending, the result register holds, the pending item
//   waits in the input register, and in_i.ready drops only once both are full.
// Reset: rst_ni (asynchronous, active low) empties both registers and puts the
//   window in its reset state: disarmed, index 0, disabled, timeout, counter
//   and both shadows all ones.
module byte_bus_watchdog_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbwd_in_if.sink     in_i,
  bbwd_out_if.source  out_o
);

  logic              in_valid_q;
  bbwd_pkg::item_t   in_item_q;
  logic              out_valid_q;
  bbwd_pkg::result_t out_res_q;
  bbwd_pkg::result_t core_res;
  logic              advance;

  // core steps when there is an item and the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q.mode       <= in_i.mode;
      in_item_q.write_byte <= in_i.write_byte;
    end
  end

  bbwd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_byte      = out_res_q.read_byte;
  assign out_o.watchdog_fired = out_res_q.watchdog_fired;

endmodule

>>> rtl/bbwd_core.sv
// Register window, watchdog counter and fire logic; one item per step.
module bbwd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bbwd_pkg::item_t   item_i,
  output bbwd_pkg::result_t result_o
);

  logic                      armed_q, armed_d;
  logic [bbwd_pkg::IdxW-1:0] index_q, index_d;
  logic [7:0]                enable_q, enable_d;
  logic [31:0]               timeout_q, timeout_d;
  logic [31:0]               count_q, count_d;
  logic [31:0]               staged_q, staged_d;
  logic [31:0]               snap_q, snap_d;
  logic [7:0]                rd;
  logic                      fire;
  logic [1:0]                bank;
  logic [1:0]                lane;

  assign bank = index_q[3:2];
  assign lane = index_q[1:0];

  always_comb begin
    armed_d   = armed_q;
    index_d   = index_q;
    enable_d  = enable_q;
    timeout_d = timeout_q;
    count_d   = count_q;
    staged_d  = staged_q;
    snap_d    = snap_q;
    rd        = '0;

    unique case (bbwd_pkg::mode_e'(item_i.mode))
      bbwd_pkg::MODE_WR_MATCH: armed_d = 1'b1;
      bbwd_pkg::MODE_RD_MATCH: begin
        staged_d = timeout_q;
        snap_d   = count_q;
      end
      bbwd_pkg::MODE_DATA_WR: begin
        if (armed_q) begin
          index_d = bbwd_pkg::byte_mod_window(item_i.write_byte);
          armed_d = 1'b0;
        end else begin
          if (index_q == bbwd_pkg::OfsEnable) begin
            enable_d = item_i.write_byte;
          end else if (index_q == bbwd_pkg::OfsReload) begin
            count_d = timeout_q;
          end else if (bank == bbwd_pkg::BankTimeout) begin
            staged_d[lane*8 +: 8] = item_i.write_byte;
          end
          index_d = bbwd_pkg::next_index(index_q);
        end
      end
      bbwd_pkg::MODE_DATA_RD: begin
        if (index_q == bbwd_pkg::OfsEnable) begin
          rd = enable_q;
        end else if (bank == bbwd_pkg::BankTimeout) begin
          rd = staged_q[lane*8 +: 8];
        end else if (bank == bbwd_pkg::BankCounter) begin
          rd = snap_q[lane*8 +: 8];
        end
        index_d = bbwd_pkg::next_index(index_q);
      end
      bbwd_pkg::MODE_STOP: timeout_d = staged_q;
      bbwd_pkg::MODE_TICK: begin
        if (enable_q != '0 && count_q != '0) begin
          count_d = count_q - 32'd1;
        end
      end
      default: ;
    endcase

    // enabled and expired: fire and fall back to the reset state
    fire = (enable_d != '0) && (count_d == '0);
    if (fire) begin
      armed_d   = 1'b0;
      index_d   = '0;
      enable_d  = '0;
      timeout_d = bbwd_pkg::AllOnes;
      count_d   = bbwd_pkg::AllOnes;
      staged_d  = bbwd_pkg::AllOnes;
      snap_d    = bbwd_pkg::AllOnes;
    end
  end

  assign result_o.read_byte      = rd;
  assign result_o.watchdog_fired = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      index_q   <= '0;
      enable_q  <= '0;
      timeout_q <= bbwd_pkg::AllOnes;
      count_q   <= bbwd_pkg::AllOnes;
      staged_q  <= bbwd_pkg::AllOnes;
      snap_q    <= bbwd_pkg::AllOnes;
    end else if (step_i) begin
      armed_q   <= armed_d;
      index_q   <= index_d;
      enable_q  <= enable_d;
      timeout_q <= timeout_d;
      count_q   <= count_d;
      staged_q  <= staged_d;
      snap_q    <= snap_d;
    end
  end

endmodule
